// ===== rtl/core/p2pmsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pmsp_pkg
// Types, codes and signature constants shared by the message stream parser.
// ----------------------------------------------------------------------------
package p2pmsp_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned RoleW  = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ErrW   = 3;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register indexes (word address)
  localparam logic RegEntryMode = 1'b0;

  localparam logic [1:0] ModeDgram   = 2'd0;
  localparam logic [1:0] ModeHeaders = 2'd1;

  localparam logic [31:0] SigDgram = 32'h4A58_5441;
  localparam logic [31:0] SigMsg   = 32'h6A78_6D67;
  localparam logic [31:0] SigElem  = 32'h6A78_656C;

  localparam logic [RoleW-1:0] RoleUnparsed = 5'd0;
  localparam logic [RoleW-1:0] RoleTrailing = 5'd23;

  typedef enum logic [4:0] {
    PhIdle     = 5'd0,
    PhDsig     = 5'd1,
    PhHnamelen = 5'd2,
    PhHname    = 5'd3,
    PhHvallen  = 5'd4,
    PhHvalue   = 5'd5,
    PhMsig     = 5'd6,
    PhVersion  = 5'd7,
    PhNscount  = 5'd8,
    PhNslen    = 5'd9,
    PhNsname   = 5'd10,
    PhElcount  = 5'd11,
    PhEsig     = 5'd12,
    PhNsid     = 5'd13,
    PhFlags    = 5'd14,
    PhNamelen  = 5'd15,
    PhName     = 5'd16,
    PhTypelen  = 5'd17,
    PhType     = 5'd18,
    PhEnclen   = 5'd19,
    PhEnc      = 5'd20,
    PhContlen  = 5'd21,
    PhCont     = 5'd22
  } phase_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone      = 3'd0,
    ErrDgramSig  = 3'd1,
    ErrMsgSig    = 3'd2,
    ErrVersion   = 3'd3,
    ErrElemSig   = 3'd4
  } err_e;

  // one queued word, tagged by the front end
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       zero;
  } word_t;

  // queue head toward the parser
  typedef struct packed {
    logic  valid;
    word_t word;
  } head_t;

  function automatic logic [7:0] sig_pick(input logic [31:0] sig, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = sig[31:24];
      2'd1:    b = sig[23:16];
      2'd2:    b = sig[15:8];
      default: b = sig[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/p2pmsp_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pmsp_intf
// Valid/ready channels for packet bytes in and tagged results out.
// ----------------------------------------------------------------------------
interface p2pmsp_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source (output valid, data_byte, packet_start, input ready);
  modport sink   (input valid, data_byte, packet_start, output ready);
endinterface

interface p2pmsp_out_if import p2pmsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RoleW-1:0]  byte_role;
  logic [ValueW-1:0] field_value;
  logic              field_done;
  logic [ErrW-1:0]   error_code;

  modport source (output valid, byte_role, field_value, field_done, error_code, input ready);
  modport sink   (input valid, byte_role, field_value, field_done, error_code, output ready);
endinterface

// ===== rtl/core/p2pmsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pmsp_front
// Accepts packet bytes, tags them and holds them in a short queue.
// ----------------------------------------------------------------------------
module p2pmsp_front import p2pmsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  p2pmsp_in_if.sink   in_i,
  output head_t       head_o,
  input  logic        pop_i
);

  word_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push;
  logic                 pop;
  word_t                word_in;

  assign in_i.ready = (cnt_q != QueueCntW'(QueueDepth));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    word_in.data  = in_i.data_byte;
    word_in.start = in_i.packet_start;
    word_in.zero  = (in_i.data_byte == 8'd0);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.word  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/p2pmsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pmsp_back
// Parse state machine: tags each queued word and drives the result register.
// ----------------------------------------------------------------------------
module p2pmsp_back import p2pmsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  entry_mode_i,
  input  head_t       head_i,
  output logic        pop_o,
  p2pmsp_out_if.source res_o
);

  phase_e       phase_q, phase_d;
  logic [31:0]  left_q, left_d;
  logic [23:0]  accum_q, accum_d;
  logic [1:0]   idx_q, idx_d;
  logic         ok_q, ok_d;
  logic [15:0]  ns_q, ns_d;
  logic [2:0]   flags_q, flags_d;
  logic         halted_q, halted_d;

  logic              valid_q, valid_d;
  logic [RoleW-1:0]  role_q, role_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              done_q, done_d;
  err_e              err_q, err_d;

  logic [7:0]  b;
  logic [31:0] num;

  assign pop_o = head_i.valid && (!valid_q || res_o.ready);
  assign b     = head_i.word.data;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    accum_d  = accum_q;
    idx_d    = idx_q;
    ok_d     = ok_q;
    ns_d     = ns_q;
    flags_d  = flags_q;
    halted_d = halted_q;
    role_d   = RoleUnparsed;
    value_d  = '0;
    done_d   = 1'b0;
    err_d    = ErrNone;

    // restart on packet start, then parse this word as the first byte
    if (head_i.word.start) begin
      left_d   = '0;
      accum_d  = '0;
      idx_d    = '0;
      ok_d     = 1'b1;
      ns_d     = '0;
      flags_d  = '0;
      halted_d = 1'b0;
      if (entry_mode_i == ModeDgram) begin
        phase_d = PhDsig;
      end else if (entry_mode_i == ModeHeaders) begin
        phase_d = PhHnamelen;
      end else begin
        phase_d = PhMsig;
      end
    end

    num = {accum_d, b};

    if (phase_d == PhIdle) begin
      role_d = RoleUnparsed;
    end else if (halted_d) begin
      role_d = RoleTrailing;
    end else begin
      role_d = RoleW'(phase_d);
      case (phase_d)
        PhDsig, PhMsig, PhEsig: begin
          if (phase_d == PhDsig) begin
            if (b != sig_pick(SigDgram, idx_d)) ok_d = 1'b0;
          end else if (phase_d == PhMsig) begin
            if (b != sig_pick(SigMsg, idx_d)) ok_d = 1'b0;
          end else begin
            if (b != sig_pick(SigElem, idx_d)) ok_d = 1'b0;
          end
          if (idx_d == 2'd3) begin
            idx_d = '0;
            if (ok_d) begin
              if (phase_d == PhDsig) begin
                phase_d = PhHnamelen;
              end else if (phase_d == PhMsig) begin
                phase_d = PhVersion;
              end else begin
                phase_d = PhNsid;
              end
            end else if (phase_d == PhDsig) begin
              err_d    = ErrDgramSig;
              halted_d = 1'b1;
            end else if (phase_d == PhMsig) begin
              err_d    = ErrMsgSig;
              halted_d = 1'b1;
            end else begin
              // retry the next four bytes as a signature
              err_d = ErrElemSig;
            end
            ok_d = 1'b1;
          end else begin
            idx_d = idx_d + 2'd1;
          end
        end
        PhHnamelen: begin
          value_d = {24'd0, b};
          done_d  = 1'b1;
          if (head_i.word.zero) begin
            phase_d = PhMsig;
          end else begin
            left_d  = {24'd0, b};
            phase_d = PhHname;
          end
        end
        PhNslen: begin
          value_d = {24'd0, b};
          done_d  = 1'b1;
          if (head_i.word.zero) begin
            if (ns_d != '0) ns_d = ns_d - 16'd1;
            phase_d = (ns_d != '0) ? PhNslen : PhElcount;
          end else begin
            left_d  = {24'd0, b};
            phase_d = PhNsname;
          end
        end
        PhVersion: begin
          if (!head_i.word.zero) begin
            err_d    = ErrVersion;
            halted_d = 1'b1;
          end else begin
            phase_d = PhNscount;
          end
        end
        PhNsid: begin
          phase_d = PhFlags;
        end
        PhFlags: begin
          flags_d = b[2:0];
          phase_d = PhNamelen;
        end
        PhHvallen, PhNscount, PhElcount, PhNamelen, PhTypelen, PhEnclen, PhContlen: begin
          if ((phase_d == PhContlen) ? (idx_d == 2'd3) : (idx_d != 2'd0)) begin
            value_d = num;
            done_d  = 1'b1;
            accum_d = '0;
            idx_d   = '0;
            case (phase_d)
              PhHvallen: begin
                if (num == '0) phase_d = PhHnamelen;
                else begin
                  left_d  = num;
                  phase_d = PhHvalue;
                end
              end
              PhNscount: begin
                ns_d    = num[15:0];
                phase_d = (num[15:0] != '0) ? PhNslen : PhElcount;
              end
              PhElcount: begin
                phase_d = PhEsig;
              end
              PhNamelen: begin
                if (num == '0) begin
                  if (flags_d[0]) phase_d = PhTypelen;
                  else phase_d = flags_d[1] ? PhEnclen : PhContlen;
                end else begin
                  left_d  = num;
                  phase_d = PhName;
                end
              end
              PhTypelen: begin
                if (num == '0) phase_d = flags_d[1] ? PhEnclen : PhContlen;
                else begin
                  left_d  = num;
                  phase_d = PhType;
                end
              end
              PhEnclen: begin
                if (num == '0) phase_d = PhContlen;
                else begin
                  left_d  = num;
                  phase_d = PhEnc;
                end
              end
              default: begin
                if (num == '0) phase_d = PhEsig;
                else begin
                  left_d  = num;
                  phase_d = PhCont;
                end
              end
            endcase
          end else begin
            accum_d = num[23:0];
            idx_d   = idx_d + 2'd1;
          end
        end
        PhHname, PhHvalue, PhNsname, PhName, PhType, PhEnc, PhCont: begin
          if (left_d != '0) left_d = left_d - 32'd1;
          if (left_d == '0) begin
            case (phase_d)
              PhHname:  phase_d = PhHvallen;
              PhHvalue: phase_d = PhHnamelen;
              PhNsname: begin
                if (ns_d != '0) ns_d = ns_d - 16'd1;
                phase_d = (ns_d != '0) ? PhNslen : PhElcount;
              end
              PhName: begin
                if (flags_d[0]) phase_d = PhTypelen;
                else phase_d = flags_d[1] ? PhEnclen : PhContlen;
              end
              PhType:   phase_d = flags_d[1] ? PhEnclen : PhContlen;
              PhEnc:    phase_d = PhContlen;
              default:  phase_d = PhEsig;
            endcase
          end
        end
        default: begin
          role_d  = RoleUnparsed;
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      left_q   <= '0;
      accum_q  <= '0;
      idx_q    <= '0;
      ok_q     <= 1'b1;
      ns_q     <= '0;
      flags_q  <= '0;
      halted_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        phase_q  <= phase_d;
        left_q   <= left_d;
        accum_q  <= accum_d;
        idx_q    <= idx_d;
        ok_q     <= ok_d;
        ns_q     <= ns_d;
        flags_q  <= flags_d;
        halted_q <= halted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      role_q  <= role_d;
      value_q <= value_d;
      done_q  <= done_d;
      err_q   <= err_d;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.byte_role   = role_q;
  assign res_o.field_value = value_q;
  assign res_o.field_done  = done_q;
  assign res_o.error_code  = err_q;

endmodule

// ===== rtl/core/p2p_message_stream_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2p_message_stream_parser_top
// Byte-serial parser that tags every packet byte with its role in the message.
// ----------------------------------------------------------------------------
//  channel | direction | word contents
//  in_i    | sink      | data_byte, packet_start
//  res_o   | source    | byte_role, field_value, field_done, error_code
//  apb     | slave     | entry_mode at word address 0
//
//  One byte per cycle sustained while res_o.ready holds; the parse step
//  registers a byte's result at the edge that pops it from the two-word queue.
//  Reset clears the parse state to waiting for a packet start, entry_mode to 0.
//  The input queue keeps accepting while a result waits on res_o.ready,
//  until it holds two words.
// ----------------------------------------------------------------------------
module p2p_message_stream_parser_top import p2pmsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  p2pmsp_in_if.sink           in_i,
  p2pmsp_out_if.source        res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [1:0] entry_mode_q, entry_mode_d;
  logic       cfg_wr;
  head_t      head;
  logic       pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    entry_mode_d = entry_mode_q;
    if (cfg_wr && (paddr[2] == RegEntryMode)) begin
      entry_mode_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_mode_q <= ModeDgram;
    end else begin
      entry_mode_q <= entry_mode_d;
    end
  end

  assign prdata = (paddr[2] == RegEntryMode) ? {30'd0, entry_mode_q} : '0;

  p2pmsp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  p2pmsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_mode_i (entry_mode_q),
    .head_i       (head),
    .pop_o        (pop),
    .res_o        (res_o)
  );

`ifndef SYNTHESIS
  // parser never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

  // an error shows only on a signature or version byte
  a_err_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.error_code != ErrNone) |->
      (res_o.byte_role == RoleW'(PhDsig) || res_o.byte_role == RoleW'(PhMsig) ||
       res_o.byte_role == RoleW'(PhVersion) || res_o.byte_role == RoleW'(PhEsig)))
    else $error("error on a byte that is not a signature or version");

  // value is zero unless a numeric field completes
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.field_done) |-> (res_o.field_value == '0))
    else $error("field value without field done");

  // a completed field never coincides with an error
  a_done_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.field_done) |-> (res_o.error_code == ErrNone))
    else $error("field done together with error");
`endif

endmodule

// ===== verif/tb_p2p_message_stream_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_p2p_message_stream_parser_top
// Drives packet bytes into the parser under random idling on both channels and
// checks each result against a cycle-free parse tracker or typed table rows.
// A short directed table runs first, then random packets in every entry mode.
// ----------------------------------------------------------------------------
module tb_p2p_message_stream_parser_top;
  import p2pmsp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 400;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldLen    = 150;

  localparam logic [1:0] ModeBare  = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam logic [1:0] ModeOrder [4] = '{ModeBare, ModeHeaders, ModeSpare, ModeDgram};

  typedef struct packed {
    logic [RoleW-1:0]  role;
    logic [ValueW-1:0] value;
    logic              done;
    logic [ErrW-1:0]   err;
  } tag_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_in_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    tag_t       tag;
  } dir_row_t;

  localparam dir_row_t DirRows [23] = '{
    '{8'h00,            1'b0, 1'b1, '{RoleUnparsed, 32'd0, 1'b0, ErrNone}},
    '{8'hFF,            1'b0, 1'b1, '{RoleUnparsed, 32'd0, 1'b0, ErrNone}},
    '{SigDgram[31:24],  1'b1, 1'b0, '0},
    '{SigDgram[23:16],  1'b0, 1'b0, '0},
    '{SigDgram[15:8],   1'b0, 1'b0, '0},
    '{8'h00,            1'b0, 1'b1, '{PhDsig, 32'd0, 1'b0, ErrDgramSig}},
    '{8'hFF,            1'b0, 1'b1, '{RoleTrailing, 32'd0, 1'b0, ErrNone}},
    '{SigDgram[31:24],  1'b1, 1'b0, '0},
    '{SigDgram[23:16],  1'b0, 1'b0, '0},
    '{SigDgram[15:8],   1'b0, 1'b0, '0},
    '{SigDgram[7:0],    1'b0, 1'b0, '0},
    '{8'hFF,            1'b0, 1'b1, '{PhHnamelen, 32'd255, 1'b1, ErrNone}},
    // restart in the middle of a header name
    '{SigDgram[31:24],  1'b1, 1'b0, '0},
    '{SigDgram[23:16],  1'b0, 1'b0, '0},
    '{SigDgram[15:8],   1'b0, 1'b0, '0},
    '{SigDgram[7:0],    1'b0, 1'b0, '0},
    '{8'h00,            1'b0, 1'b1, '{PhHnamelen, 32'd0, 1'b1, ErrNone}},
    '{SigMsg[31:24],    1'b0, 1'b0, '0},
    '{SigMsg[23:16],    1'b0, 1'b0, '0},
    '{SigMsg[15:8],     1'b0, 1'b0, '0},
    '{SigMsg[7:0],      1'b0, 1'b0, '0},
    '{8'hFF,            1'b0, 1'b1, '{PhVersion, 32'd0, 1'b0, ErrVersion}},
    '{8'h00,            1'b0, 1'b1, '{RoleTrailing, 32'd0, 1'b0, ErrNone}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  p2pmsp_in_if  in_if ();
  p2pmsp_out_if out_if ();

  p2p_message_stream_parser_top i_dut (
    .clk_i,
    .rst_ni,
    .in_i   (in_if),
    .res_o  (out_if),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parse tracker state
  phase_e      p_phase;
  logic [31:0] p_left;
  logic [31:0] p_accum;
  logic [1:0]  p_pos;
  logic        p_sig_ok;
  logic [15:0] p_ns_left;
  logic [2:0]  p_flags;
  logic        p_halted;
  logic [1:0]  p_mode;

  tag_t        tags_due [$];
  byte_in_t    stim_q [$];
  int unsigned n_fail;
  int unsigned n_sent;
  int unsigned cycle_cnt;

  function automatic logic sig_match(input logic [7:0] b, input logic [31:0] sig);
    if (b != sig[8*(3-p_pos) +: 8]) p_sig_ok = 1'b0;
    if (p_pos == 2'd3) begin
      p_pos = '0;
      return 1'b1;
    end
    p_pos++;
    return 1'b0;
  endfunction

  // big-endian number; last is the index of its final byte
  function automatic logic num_step(input logic [7:0] b, input logic [1:0] last,
                                    output logic [31:0] v);
    p_accum = {p_accum[23:0], b};
    v = p_accum;
    if (p_pos >= last) begin
      p_accum = '0;
      p_pos = '0;
      return 1'b1;
    end
    p_pos++;
    return 1'b0;
  endfunction

  function automatic logic take_field(input logic [31:0] len, input phase_e ph);
    if (len == 0) return 1'b0;
    p_left = len;
    p_phase = ph;
    return 1'b1;
  endfunction

  function automatic logic count_data();
    if (p_left != 0) p_left--;
    return p_left == 0;
  endfunction

  function automatic void ns_next();
    if (p_ns_left != 0) p_ns_left--;
    p_phase = (p_ns_left != 0) ? PhNslen : PhElcount;
  endfunction

  function automatic void after_type();
    p_phase = p_flags[1] ? PhEnclen : PhContlen;
  endfunction

  function automatic void after_name();
    if (p_flags[0]) p_phase = PhTypelen;
    else after_type();
  endfunction

  function automatic tag_t tag_byte(input logic [7:0] b, input logic start);
    tag_t        r;
    logic [31:0] v;
    r = '0;
    v = '0;
    if (start) begin
      p_left = '0;
      p_accum = '0;
      p_pos = '0;
      p_sig_ok = 1'b1;
      p_ns_left = '0;
      p_flags = '0;
      p_halted = 1'b0;
      case (p_mode)
        ModeDgram:   p_phase = PhDsig;
        ModeHeaders: p_phase = PhHnamelen;
        default:     p_phase = PhMsig;
      endcase
    end
    if (p_phase == PhIdle) begin
      r.role = RoleUnparsed;
    end else if (p_halted) begin
      r.role = RoleTrailing;
    end else begin
      r.role = p_phase;
      case (p_phase)
        PhDsig: begin
          if (sig_match(b, SigDgram)) begin
            if (p_sig_ok) begin
              p_phase = PhHnamelen;
            end else begin
              r.err = ErrDgramSig;
              p_halted = 1'b1;
            end
            p_sig_ok = 1'b1;
          end
        end
        PhHnamelen: begin
          r.value = 32'(b);
          r.done = 1'b1;
          if (b == 8'h00) p_phase = PhMsig;
          else void'(take_field(32'(b), PhHname));
        end
        PhHname: if (count_data()) p_phase = PhHvallen;
        PhHvallen: begin
          if (num_step(b, 2'd1, v)) begin
            r.value = v;
            r.done = 1'b1;
            if (!take_field(v, PhHvalue)) p_phase = PhHnamelen;
          end
        end
        PhHvalue: if (count_data()) p_phase = PhHnamelen;
        PhMsig: begin
          if (sig_match(b, SigMsg)) begin
            if (p_sig_ok) begin
              p_phase = PhVersion;
            end else begin
              r.err = ErrMsgSig;
              p_halted = 1'b1;
            end
            p_sig_ok = 1'b1;
          end
        end
        PhVersion: begin
          if (b != 8'h00) begin
            r.err = ErrVersion;
            p_halted = 1'b1;
          end else begin
            p_phase = PhNscount;
          end
        end
        PhNscount: begin
          if (num_step(b, 2'd1, v)) begin
            r.value = v;
            r.done = 1'b1;
            p_ns_left = v[15:0];
            p_phase = (v[15:0] != 0) ? PhNslen : PhElcount;
          end
        end
        PhNslen: begin
          r.value = 32'(b);
          r.done = 1'b1;
          if (!take_field(32'(b), PhNsname)) ns_next();
        end
        PhNsname: if (count_data()) ns_next();
        PhElcount: begin
          if (num_step(b, 2'd1, v)) begin
            r.value = v;
            r.done = 1'b1;
            p_phase = PhEsig;
          end
        end
        PhEsig: begin
          if (sig_match(b, SigElem)) begin
            if (p_sig_ok) p_phase = PhNsid;
            else r.err = ErrElemSig;
            p_sig_ok = 1'b1;
          end
        end
        PhNsid: p_phase = PhFlags;
        PhFlags: begin
          p_flags = b[2:0];
          p_phase = PhNamelen;
        end
        PhNamelen: begin
          if (num_step(b, 2'd1, v)) begin
            r.value = v;
            r.done = 1'b1;
            if (!take_field(v, PhName)) after_name();
          end
        end
        PhName: if (count_data()) after_name();
        PhTypelen: begin
          if (num_step(b, 2'd1, v)) begin
            r.value = v;
            r.done = 1'b1;
            if (!take_field(v, PhType)) after_type();
          end
        end
        PhType: if (count_data()) after_type();
        PhEnclen: begin
          if (num_step(b, 2'd1, v)) begin
            r.value = v;
            r.done = 1'b1;
            if (!take_field(v, PhEnc)) p_phase = PhContlen;
          end
        end
        PhEnc: if (count_data()) p_phase = PhContlen;
        PhContlen: begin
          if (num_step(b, 2'd3, v)) begin
            r.value = v;
            r.done = 1'b1;
            if (!take_field(v, PhCont)) p_phase = PhEsig;
          end
        end
        PhCont: if (count_data()) p_phase = PhEsig;
        default: begin
          r.role = RoleUnparsed;
          p_phase = PhIdle;
        end
      endcase
    end
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put(input logic [7:0] b);
    stim_q.push_back('{b, 1'b0});
  endtask

  task automatic put_num(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) put(v[8*i +: 8]);
  endtask

  task automatic put_blob(input int n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  // corrupt one byte of the signature when asked
  task automatic put_sig(input logic [31:0] sig, input bit bad);
    int k;
    k = bad ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 4; i++) put((i == k) ? 8'($urandom_range(0, 255)) : sig[8*(3-i) +: 8]);
  endtask

  task automatic build_packet(input logic [1:0] mode);
    int unsigned s0;
    int unsigned kind;
    int unsigned n;
    logic [7:0]  fl;
    bit          bad;
    s0 = stim_q.size();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      put_blob($urandom_range(1, 8));
    end else begin
      if (mode == ModeDgram) put_sig(SigDgram, $urandom_range(0, 9) == 0);
      if (mode == ModeDgram || mode == ModeHeaders) begin
        repeat ($urandom_range(0, 2)) begin
          n = $urandom_range(1, 3);
          put(8'(n));
          put_blob(n);
          n = $urandom_range(0, 3);
          put_num(n, 2);
          put_blob(n);
        end
        put(8'h00);
      end
      put_sig(SigMsg, $urandom_range(0, 11) == 0);
      put(($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      n = $urandom_range(0, 2);
      put_num(n, 2);
      repeat (n) begin
        n = $urandom_range(0, 3);
        put(8'(n));
        put_blob(n);
      end
      put_num($urandom_range(0, 16'hFFFF), 2);
      repeat ($urandom_range(1, 2)) begin
        bad = ($urandom_range(0, 7) == 0);
        put_sig(SigElem, bad);
        // resync on a clean signature after a broken one
        if (bad) put_sig(SigElem, 1'b0);
        put_blob(1);
        fl = 8'($urandom_range(0, 255));
        put(fl);
        n = $urandom_range(0, 3);
        put_num(n, 2);
        put_blob(n);
        if (fl[0]) begin
          n = $urandom_range(0, 3);
          put_num(n, 2);
          put_blob(n);
        end
        if (fl[1]) begin
          n = $urandom_range(0, 3);
          put_num(n, 2);
          put_blob(n);
        end
        n = $urandom_range(0, 4);
        put_num(n, 4);
        put_blob(n);
      end
      if (kind == 1 && stim_q.size() - s0 > 1) begin
        repeat ($urandom_range(1, stim_q.size() - s0 - 1)) void'(stim_q.pop_back());
      end else if (kind == 2) begin
        // huge content length, cut off by the next packet
        put_sig(SigElem, 1'b0);
        put_num(32'd0, 4);
        put_num($urandom(), 4);
        put_blob($urandom_range(1, 4));
      end
    end
    stim_q[s0].start = 1'b1;
  endtask

  task automatic send_word(input byte_in_t w, input int gap, input logic typed,
                           input tag_t typed_tag);
    tag_t pred;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= w.data;
    in_if.packet_start <= w.start;
    do @(posedge clk_i); while (!in_if.ready);
    pred = tag_byte(w.data, w.start);
    tags_due.push_back(typed ? typed_tag : pred);
    n_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (tags_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check, then pick the next ready level
  int unsigned hold_left = 0;
  int unsigned rx_wait = 0;
  bit          hold_done = 1'b0;
  bit          rx_quiet = 1'b0;

  always @(posedge clk_i) begin
    tag_t got;
    tag_t want;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.byte_role, out_if.field_value, out_if.field_done, out_if.error_code};
      if (tags_due.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected word: role %0d value %h done %0d error %0d", $time,
                 got.role, got.value, got.done, got.err);
      end else begin
        want = tags_due.pop_front();
        if (got.role !== want.role) begin
          n_fail++;
          $display("%0t: byte_role expected %0d actual %0d", $time, want.role, got.role);
        end
        if (got.value !== want.value) begin
          n_fail++;
          $display("%0t: field_value expected %h actual %h", $time, want.value, got.value);
        end
        if (got.done !== want.done) begin
          n_fail++;
          $display("%0t: field_done expected %0d actual %0d", $time, want.done, got.done);
        end
        if (got.err !== want.err) begin
          n_fail++;
          $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
        end
      end
    end
    // long hold-off once, so the input queue fills and stalls the sender
    if (!hold_done && n_sent >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      rx_wait = pick_gap(rx_quiet);
    end
    if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
  end

  initial begin
    int unsigned rand_cnt;
    int unsigned phase_idx;
    logic [1:0]  mode;
    bit          tx_quiet;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.packet_start = 1'b0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_fail = 0;
    n_sent = 0;
    cycle_cnt = 0;
    p_phase = PhIdle;
    p_left = '0;
    p_accum = '0;
    p_pos = '0;
    p_sig_ok = 1'b1;
    p_ns_left = '0;
    p_flags = '0;
    p_halted = 1'b0;
    p_mode = ModeDgram;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirRows[i]) begin
      send_word('{DirRows[i].data, DirRows[i].start}, pick_gap(1'b0), DirRows[i].typed,
                DirRows[i].tag);
    end

    rand_cnt = 0;
    phase_idx = 0;
    while (rand_cnt < RandItems) begin
      settle();
      mode = (phase_idx < 4) ? ModeOrder[phase_idx] : 2'($urandom_range(0, 3));
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {RegEntryMode, 2'b00};
      pwdata <= 32'(mode);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      p_mode = mode;

      tx_quiet = ($urandom_range(0, 3) == 0);
      while (stim_q.size() < PhaseItems) build_packet(mode);
      while (stim_q.size() != 0) begin
        send_word(stim_q.pop_front(), pick_gap(tx_quiet), 1'b0, '0);
        rand_cnt++;
      end
      phase_idx++;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (n_fail == 0 && tags_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/p2pmsp_pkg.sv
rtl/core/p2pmsp_intf.sv
rtl/core/p2pmsp_front.sv
rtl/core/p2pmsp_back.sv
rtl/core/p2p_message_stream_parser_top.sv
verif/tb_p2p_message_stream_parser_top.sv
